>>> src/lafe_pkg.sv
// Shared constants, command codes, control structs and width helpers for the flip engine.
package lafe_pkg;

  localparam int SEQ_LEN_DEF = 512;

  localparam int CMD_W = 2;
  localparam int POS_W = 9;
  localparam int CHG_W = 22;
  localparam int EN_W  = 26;

  localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RECOMP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EVAL   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_APPLY  = 2'd3;

  localparam int CHG_MAX = 2097151;
  localparam int CHG_MIN = -2097152;
  localparam int EN_MAX  = 67108863;

  // Control that travels alongside the registered store read data.
  typedef struct packed {
    logic valid;
    logic pre;
    logic flip;
    logic first;
    logic last;
    logic lo_ok;
    logic hi_ok;
  } stage_ctl_t;

  // Per-command pulses from the sequencer to the arithmetic unit.
  typedef struct packed {
    logic clear_chg;
    logic start_corr;
    logic commit;
  } alu_cmd_t;

  function automatic int corr_w(input int n);
    return $clog2(n) + 2;
  endfunction

  function automatic int energy_w(input int n);
    int w;
    w = 3 * $clog2(n) + 3;
    return (w > EN_W + 1) ? w : EN_W + 1;
  endfunction

endpackage

>>> src/lafe_bit_store.sv
// Sequence element store: one write port and two registered read ports.
module lafe_bit_store #(
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic                     wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic                     rd_data_a,
  output logic                     rd_data_b
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

>>> src/lafe_corr_store.sv
// Lag correlation store: one write port and one registered read port.
module lafe_corr_store #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 11
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> src/lafe_alu.sv
// Shared arithmetic unit: flip terms, lag accumulation, squaring and energy update.
module lafe_alu import lafe_pkg::*; #(
  parameter int SEQ_LEN = SEQ_LEN_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  alu_cmd_t                             cmd,
  input  stage_ctl_t                           ctl,
  input  logic                                 elem_a,
  input  logic                                 elem_b,
  input  logic signed [corr_w(SEQ_LEN)-1:0]    corr_in,
  output logic signed [corr_w(SEQ_LEN)-1:0]    corr_wr,
  output logic                                 elem_p,
  output logic signed [energy_w(SEQ_LEN)-1:0]  chg,
  output logic signed [energy_w(SEQ_LEN)-1:0]  energy
);

  localparam int CW = corr_w(SEQ_LEN);
  localparam int EW = energy_w(SEQ_LEN);

  logic                   sp_r;
  logic signed [CW-1:0]   acc_r;
  logic signed [CW-1:0]   fin_r;
  logic                   fin_v_r;
  logic signed [2*CW-1:0] prod_r;
  logic                   prod_v_r;
  logic signed [EW-1:0]   chg_r;
  logic signed [EW-1:0]   energy_r;

  logic signed [2:0]    lo_v;
  logic signed [2:0]    hi_v;
  logic signed [2:0]    v_sum;
  logic signed [2:0]    v_eff;
  logic signed [EW-1:0] c_ext;
  logic signed [EW-1:0] term;
  logic signed [CW-1:0] c_new;
  logic signed [CW-1:0] e_step;
  logic signed [CW-1:0] acc_sum;

  always_comb begin
    lo_v  = ctl.lo_ok ? (elem_a ? 3'sd1 : -3'sd1) : 3'sd0;
    hi_v  = ctl.hi_ok ? (elem_b ? 3'sd1 : -3'sd1) : 3'sd0;
    v_sum = lo_v + hi_v;
    // The lag change is d = 2*v_eff, so the energy term 2*C*d + d*d is 4*C*v_eff + 4*v_eff^2.
    v_eff = sp_r ? -v_sum : v_sum;
    c_ext = EW'(corr_in);
    if (v_eff == 3'sd1) begin
      term = (c_ext <<< 2) + EW'(4);
    end else if (v_eff == -3'sd1) begin
      term = EW'(4) - (c_ext <<< 2);
    end else if (v_eff == 3'sd2) begin
      term = (c_ext <<< 3) + EW'(16);
    end else if (v_eff == -3'sd2) begin
      term = EW'(16) - (c_ext <<< 3);
    end else begin
      term = '0;
    end
    c_new   = corr_in + (CW'(v_eff) <<< 1);
    e_step  = (elem_a == elem_b) ? CW'(1) : CW'(-1);
    acc_sum = (ctl.first ? CW'(0) : acc_r) + e_step;
    corr_wr = ctl.flip ? c_new : acc_sum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r  <= 1'b0;
      prod_v_r <= 1'b0;
      chg_r    <= '0;
      energy_r <= '0;
    end else begin
      fin_v_r  <= ctl.valid && !ctl.flip && ctl.last;
      prod_v_r <= fin_v_r;
      if (cmd.clear_chg) begin
        chg_r <= '0;
      end else if (ctl.valid && ctl.flip) begin
        chg_r <= chg_r + term;
      end
      if (cmd.start_corr) begin
        energy_r <= '0;
      end else if (cmd.commit) begin
        energy_r <= energy_r + chg_r;
      end else if (prod_v_r) begin
        energy_r <= energy_r + EW'(prod_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pre) begin
      sp_r <= elem_a;
    end
    if (ctl.valid && !ctl.flip) begin
      acc_r <= acc_sum;
    end
    fin_r  <= acc_sum;
    prod_r <= fin_r * fin_r;
  end

  assign elem_p = sp_r;
  assign chg    = chg_r;
  assign energy = energy_r;

endmodule

>>> src/labs_autocorrelation_flip_engine.sv
// Top level of the sidelobe energy engine: command sequencer, stores and result register.
//
// One command enters on the in_ channel (in_valid, in_stall; a transfer happens when
// in_valid is high and in_stall low) and gives exactly one result on the out_ channel.
// Commands: write one element, recompute all lag correlations and the energy, evaluate
// the energy change of flipping one position, or apply that flip.
// A write, or an evaluate/apply at a position >= N (N = SEQ_LEN), goes straight to the
// result. Evaluate and apply step through the lags, one lag per cycle; recompute steps
// through every element pair, one pair per cycle. The sequence store gives one pair of
// elements per cycle to the shared arithmetic unit. in_stall is high from the transfer
// until the result is loaded into the output register; a new command is taken while
// that result waits.
// A stalled result holds out_valid and its fields; the block then waits before loading
// the next result. Reset clears the energy to zero and makes all lag correlations read as
// zero until a recompute or an applied flip has rewritten them. Elements must be written
// before they are read.
module labs_autocorrelation_flip_engine import lafe_pkg::*; #(
  parameter int SEQ_LEN = SEQ_LEN_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [CMD_W-1:0]        in_cmd,
  input  logic [POS_W-1:0]        in_position,
  input  logic                    in_sign_bit,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [CHG_W-1:0] out_energy_change,
  output logic [EN_W-1:0]         out_energy
);

  localparam int AW = $clog2(SEQ_LEN);
  localparam int KW = AW + 1;
  localparam int CW = corr_w(SEQ_LEN);
  localparam int EW = energy_w(SEQ_LEN);

  localparam logic [AW-1:0] LAST_K  = AW'(SEQ_LEN - 1);
  localparam logic [KW-1:0] N_K     = KW'(SEQ_LEN);
  localparam logic [KW-1:0] LAST_IK = KW'(SEQ_LEN - 1);

  localparam logic signed [EW-1:0] CHG_HI = EW'(CHG_MAX);
  localparam logic signed [EW-1:0] CHG_LO = EW'(CHG_MIN);
  localparam logic signed [EW-1:0] EN_HI  = EW'(EN_MAX);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PRE   = 3'd1;
  localparam logic [2:0] ST_FLIP  = 3'd2;
  localparam logic [2:0] ST_CORR  = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;
  localparam logic [2:0] ST_FIN   = 3'd5;

  localparam logic [1:0] DRAIN_LAST = 2'd2;

  logic [2:0]       state_r, state_nxt;
  logic [CMD_W-1:0] cmd_r, cmd_nxt;
  logic [AW-1:0]    p_r, p_nxt;
  logic [AW-1:0]    k_r, k_nxt;
  logic [AW-1:0]    i_r, i_nxt;
  logic [1:0]       drain_r, drain_nxt;
  logic             corr_ok_r, corr_ok_nxt;
  stage_ctl_t       ctl_r, ctl_nxt;
  logic [AW-1:0]    kd_r;
  logic             out_valid_r, out_valid_nxt;
  logic signed [CHG_W-1:0] out_chg_r;
  logic [EN_W-1:0]  out_en_r;

  logic             accept;
  logic             pos_ok;
  logic             drain_done;
  logic             fin_go;
  logic [KW-1:0]    sum_pk;
  logic [KW-1:0]    sum_ik;
  logic             corr_last;
  logic [AW-1:0]    rd_addr_a;
  logic [AW-1:0]    rd_addr_b;
  logic             rd_a;
  logic             rd_b;
  logic             seq_we;
  logic [AW-1:0]    seq_wa;
  logic             seq_wd;
  logic             corr_we;
  logic [CW-1:0]    corr_rd;
  logic signed [CW-1:0] corr_in;
  logic signed [CW-1:0] corr_wr;
  logic             elem_p;
  logic signed [EW-1:0] chg;
  logic signed [EW-1:0] energy;
  alu_cmd_t         alu_cmd;
  logic signed [CHG_W-1:0] chg_sat;
  logic [EN_W-1:0]  en_sat;

  assign accept     = in_valid && (state_r == ST_IDLE);
  assign in_stall   = (state_r != ST_IDLE);
  assign pos_ok     = 32'(in_position) < 32'(SEQ_LEN);
  assign drain_done = (state_r == ST_DRAIN) && (drain_r == DRAIN_LAST);
  assign fin_go     = (state_r == ST_FIN) && (!out_valid_r || !out_stall);

  assign sum_pk    = {1'b0, p_r} + {1'b0, k_r};
  assign sum_ik    = {1'b0, i_r} + {1'b0, k_r};
  assign corr_last = (sum_ik == LAST_IK);

  // Store addressing and the control that travels with the read data.
  always_comb begin
    rd_addr_a = p_r;
    rd_addr_b = p_r;
    ctl_nxt   = '0;
    case (state_r)
      ST_PRE: begin
        ctl_nxt.pre = 1'b1;
      end
      ST_FLIP: begin
        rd_addr_a     = p_r - k_r;
        rd_addr_b     = sum_pk[AW-1:0];
        ctl_nxt.valid = 1'b1;
        ctl_nxt.flip  = 1'b1;
        ctl_nxt.lo_ok = (p_r >= k_r);
        ctl_nxt.hi_ok = (sum_pk < N_K);
      end
      ST_CORR: begin
        rd_addr_a     = i_r;
        rd_addr_b     = sum_ik[AW-1:0];
        ctl_nxt.valid = 1'b1;
        ctl_nxt.first = (i_r == '0);
        ctl_nxt.last  = corr_last;
      end
      default: begin
        ctl_nxt = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    p_nxt       = p_r;
    k_nxt       = k_r;
    i_nxt       = i_r;
    drain_nxt   = drain_r;
    corr_ok_nxt = corr_ok_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd_nxt = in_cmd;
          p_nxt   = AW'(in_position);
          k_nxt   = AW'(1);
          i_nxt   = '0;
          case (in_cmd)
            CMD_WRITE: begin
              state_nxt = ST_FIN;
            end
            CMD_RECOMP: begin
              state_nxt = ST_CORR;
            end
            CMD_EVAL, CMD_APPLY: begin
              state_nxt = pos_ok ? ST_PRE : ST_FIN;
            end
            default: begin
              state_nxt = ST_FIN;
            end
          endcase
        end
      end
      ST_PRE: begin
        state_nxt = ST_FLIP;
      end
      ST_FLIP: begin
        if (k_r == LAST_K) begin
          state_nxt = ST_DRAIN;
          drain_nxt = '0;
        end else begin
          k_nxt = k_r + AW'(1);
        end
      end
      ST_CORR: begin
        if (corr_last) begin
          i_nxt = '0;
          if (k_r == LAST_K) begin
            state_nxt = ST_DRAIN;
            drain_nxt = '0;
          end else begin
            k_nxt = k_r + AW'(1);
          end
        end else begin
          i_nxt = i_r + AW'(1);
        end
      end
      ST_DRAIN: begin
        if (drain_r == DRAIN_LAST) begin
          state_nxt = ST_FIN;
          if (cmd_r == CMD_RECOMP || cmd_r == CMD_APPLY) begin
            corr_ok_nxt = 1'b1;
          end
        end else begin
          drain_nxt = drain_r + 2'd1;
        end
      end
      ST_FIN: begin
        if (fin_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // An applied flip inverts its element once every lag has been updated.
  always_comb begin
    seq_we = 1'b0;
    seq_wa = p_r;
    seq_wd = ~elem_p;
    if (accept) begin
      seq_we = (in_cmd == CMD_WRITE) && pos_ok;
      seq_wa = AW'(in_position);
      seq_wd = in_sign_bit;
    end else if (drain_done && cmd_r == CMD_APPLY) begin
      seq_we = 1'b1;
    end
  end

  assign corr_in = corr_ok_r ? signed'(corr_rd) : CW'(0);
  assign corr_we = ctl_r.valid &&
                   ((ctl_r.flip && cmd_r == CMD_APPLY) || (!ctl_r.flip && ctl_r.last));

  assign alu_cmd.clear_chg  = accept;
  assign alu_cmd.start_corr = accept && (in_cmd == CMD_RECOMP);
  assign alu_cmd.commit     = drain_done && (cmd_r == CMD_APPLY);

  always_comb begin
    if (chg > CHG_HI) begin
      chg_sat = CHG_W'(CHG_MAX);
    end else if (chg < CHG_LO) begin
      chg_sat = CHG_W'(CHG_MIN);
    end else begin
      chg_sat = chg[CHG_W-1:0];
    end
    if (energy < 0) begin
      en_sat = '0;
    end else if (energy > EN_HI) begin
      en_sat = EN_W'(EN_MAX);
    end else begin
      en_sat = energy[EN_W-1:0];
    end
  end

  assign out_valid_nxt = (out_valid_r && out_stall) || fin_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      drain_r     <= '0;
      corr_ok_r   <= 1'b0;
      ctl_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      drain_r     <= drain_nxt;
      corr_ok_r   <= corr_ok_nxt;
      ctl_r       <= ctl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    p_r   <= p_nxt;
    k_r   <= k_nxt;
    i_r   <= i_nxt;
    kd_r  <= k_r;
    if (fin_go) begin
      out_chg_r <= chg_sat;
      out_en_r  <= en_sat;
    end
  end

  lafe_bit_store #(
    .DEPTH (SEQ_LEN)
  ) u_seq (
    .clk       (clk),
    .wr_en     (seq_we),
    .wr_addr   (seq_wa),
    .wr_data   (seq_wd),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  lafe_corr_store #(
    .DEPTH (SEQ_LEN),
    .WIDTH (CW)
  ) u_corr (
    .clk     (clk),
    .wr_en   (corr_we),
    .wr_addr (kd_r),
    .wr_data (corr_wr),
    .rd_addr (k_r),
    .rd_data (corr_rd)
  );

  lafe_alu #(
    .SEQ_LEN (SEQ_LEN)
  ) u_alu (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (alu_cmd),
    .ctl     (ctl_r),
    .elem_a  (rd_a),
    .elem_b  (rd_b),
    .corr_in (corr_in),
    .corr_wr (corr_wr),
    .elem_p  (elem_p),
    .chg     (chg),
    .energy  (energy)
  );

  assign out_valid         = out_valid_r;
  assign out_energy_change = out_chg_r;
  assign out_energy        = out_en_r;

endmodule

>>> src/lafe_checker.sv
// Port-level checker for the flip engine and its bind to the top level.
module lafe_checker import lafe_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic signed [CHG_W-1:0] out_energy_change,
  input logic [EN_W-1:0]         out_energy
);

  // Every command keeps the block busy in the cycle after its transfer.
  a_busy_after_transfer: assert property (
    @(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall
  ) else $error("input not stalled after a command transfer");

  // A result appears only after the block has been busy with a command.
  a_result_after_busy: assert property (
    @(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall)
  ) else $error("result appeared without a command in progress");

  // A stalled result stays offered and unchanged.
  a_result_held: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_energy) && $stable(out_energy_change))
  ) else $error("stalled result changed or dropped");

endmodule

bind labs_autocorrelation_flip_engine lafe_checker u_lafe_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_energy_change (out_energy_change),
  .out_energy        (out_energy)
);

>>> tb/sv/labs_autocorrelation_flip_engine_tb.sv
// Self-checking testbench for the sidelobe energy flip engine, with a scoreboard class.
module labs_autocorrelation_flip_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lafe_pkg::*;

  localparam int          SEQ_N       = SEQ_LEN_DEF;
  localparam int          FLIP_GAIN   = -2;
  localparam int          RAND_N      = 640;
  localparam int          QUIET_N     = 80;
  localparam int          TAIL_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;

  typedef struct {
    logic signed [CHG_W-1:0] chg;
    logic [EN_W-1:0]         en;
  } energy_result_t;

  class energy_scoreboard;
    bit             plus_elem [SEQ_N];
    int             lag_corr [SEQ_N];
    longint         side_energy;
    energy_result_t energy_due [$];
    int             fails;
    int             checked;
    int             cmd_count [4];

    function new();
      foreach (plus_elem[i]) plus_elem[i] = 1'b0;
      foreach (lag_corr[i]) lag_corr[i] = 0;
      side_energy = 0;
      fails = 0;
      checked = 0;
      foreach (cmd_count[i]) cmd_count[i] = 0;
    endfunction

    function int elem(int i);
      return plus_elem[i] ? 1 : -1;
    endfunction

    // Change of the lag-k correlation when position p changes sign.
    function int lag_shift(int p, int k);
      int v;
      v = 0;
      if (p >= k) v += elem(p - k);
      if (p + k < SEQ_N) v += elem(p + k);
      return FLIP_GAIN * elem(p) * v;
    endfunction

    function longint flip_delta_energy(int p);
      longint acc;
      longint d;
      acc = 0;
      for (int k = 1; k < SEQ_N; k++) begin
        d = lag_shift(p, k);
        acc += 2 * longint'(lag_corr[k]) * d + d * d;
      end
      return acc;
    endfunction

    function void rebuild_correlations();
      int acc;
      side_energy = 0;
      lag_corr[0] = 0;
      for (int k = 1; k < SEQ_N; k++) begin
        acc = 0;
        for (int i = 0; i + k < SEQ_N; i++) acc += elem(i) * elem(i + k);
        lag_corr[k] = acc;
        side_energy += longint'(acc) * acc;
      end
    endfunction

    function void commit_flip(int p);
      for (int k = 1; k < SEQ_N; k++) lag_corr[k] += lag_shift(p, k);
      plus_elem[p] = ~plus_elem[p];
    endfunction

    function void note_command(logic [CMD_W-1:0] op, logic [POS_W-1:0] pos, logic sgn);
      longint         chg;
      longint         en;
      int             p;
      energy_result_t r;
      chg = 0;
      p = pos;
      cmd_count[op]++;
      case (op)
        CMD_WRITE: begin
          if (p < SEQ_N) plus_elem[p] = sgn;
        end
        CMD_RECOMP: begin
          rebuild_correlations();
        end
        default: begin
          if (p < SEQ_N) begin
            chg = flip_delta_energy(p);
            if (op == CMD_APPLY) begin
              commit_flip(p);
              side_energy += chg;
            end
          end
        end
      endcase
      if (chg > CHG_MAX) chg = CHG_MAX;
      if (chg < CHG_MIN) chg = CHG_MIN;
      en = side_energy;
      if (en < 0) en = 0;
      if (en > EN_MAX) en = EN_MAX;
      r.chg = chg[CHG_W-1:0];
      r.en  = en[EN_W-1:0];
      energy_due.push_back(r);
    endfunction

    function int pending();
      return energy_due.size();
    endfunction

    task report_mismatch(string msg);
      fails++;
      if (fails <= 200) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(logic signed [CHG_W-1:0] chg, logic [EN_W-1:0] en);
      energy_result_t r;
      checked++;
      if (energy_due.size() == 0) begin
        report_mismatch($sformatf("result with none due (change %0d, energy %0d)", chg, en));
      end else begin
        r = energy_due.pop_front();
        if (chg !== r.chg)
          report_mismatch($sformatf("energy_change got %0d, expected %0d", chg, r.chg));
        if (en !== r.en)
          report_mismatch($sformatf("energy got %0d, expected %0d", en, r.en));
      end
    endtask
  endclass

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [CMD_W-1:0]        in_cmd;
  logic [POS_W-1:0]        in_position;
  logic                    in_sign_bit;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [CHG_W-1:0] out_energy_change;
  logic [EN_W-1:0]         out_energy;

  energy_scoreboard sb;
  bit               quiet;
  int unsigned      cycle_count;

  labs_autocorrelation_flip_engine #(.SEQ_LEN(SEQ_N)) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_position       (in_position),
    .in_sign_bit       (in_sign_bit),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_energy_change (out_energy_change),
    .out_energy        (out_energy)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("labs_autocorrelation_flip_engine_tb: FAIL");
    $finish;
  end

  // Receiver back-pressure: random stall bursts, none once the run goes quiet.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_energy_change, out_energy);
  end

  // Holds the command until its transfer, then books the prediction.
  task automatic send_cmd(logic [CMD_W-1:0] op, logic [POS_W-1:0] pos, logic sgn);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_cmd      <= op;
    in_position <= pos;
    in_sign_bit <= sgn;
    do @(posedge clk); while (in_stall);
    sb.note_command(op, pos, sgn);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int               pick;
    int               recomp_at [3];
    logic [CMD_W-1:0] op;
    logic [POS_W-1:0] pos;
    logic             sgn;

    sb = new();
    quiet = 1'b0;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_cmd      <= CMD_WRITE;
    in_position <= '0;
    in_sign_bit <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Every element is written before anything reads the sequence.
    for (int p = 0; p < SEQ_N; p++) send_cmd(CMD_WRITE, POS_W'(p), 1'b1);

    // Flips on the cleared correlations, before any recompute.
    send_cmd(CMD_EVAL, POS_W'(0), 1'b0);
    send_cmd(CMD_EVAL, POS_W'(SEQ_N - 1), 1'b1);
    send_cmd(CMD_EVAL, POS_W'(255), 1'b0);
    send_cmd(CMD_APPLY, POS_W'(255), 1'b1);
    send_cmd(CMD_EVAL, POS_W'(255), 1'b0);
    // A write leaves the correlations stale until the next recompute.
    send_cmd(CMD_WRITE, POS_W'(255), 1'b1);
    send_cmd(CMD_EVAL, POS_W'(100), 1'b1);
    // All-plus sequence gives the largest energy.
    send_cmd(CMD_RECOMP, POS_W'(SEQ_N - 1), 1'b1);
    send_cmd(CMD_EVAL, POS_W'(0), 1'b1);
    send_cmd(CMD_EVAL, POS_W'(SEQ_N - 1), 1'b0);
    send_cmd(CMD_EVAL, POS_W'(256), 1'b1);
    send_cmd(CMD_APPLY, POS_W'(256), 1'b0);
    send_cmd(CMD_APPLY, POS_W'(256), 1'b1);
    send_cmd(CMD_APPLY, POS_W'(0), 1'b0);
    send_cmd(CMD_APPLY, POS_W'(SEQ_N - 1), 1'b1);
    send_cmd(CMD_WRITE, POS_W'(10), 1'b0);
    send_cmd(CMD_WRITE, POS_W'(400), 1'b0);
    send_cmd(CMD_APPLY, POS_W'(10), 1'b0);
    send_cmd(CMD_EVAL, POS_W'(400), 1'b1);
    wait_for_results();

    for (int j = 0; j < 3; j++)
      recomp_at[j] = j * (RAND_N / 3) + $urandom_range(RAND_N / 6, RAND_N / 3 - 1);

    for (int i = 0; i < RAND_N; i++) begin
      quiet = (i >= RAND_N - QUIET_N);
      if (i == RAND_N / 2) wait_for_results();
      pick = $urandom_range(0, 99);
      if (i == recomp_at[0] || i == recomp_at[1] || i == recomp_at[2]) op = CMD_RECOMP;
      else if (pick < 45) op = CMD_WRITE;
      else if (pick < 70) op = CMD_EVAL;
      else op = CMD_APPLY;
      if ($urandom_range(0, 7) == 0)
        pos = $urandom_range(0, 1) ? POS_W'($urandom_range(SEQ_N - 2, SEQ_N - 1))
                                   : POS_W'($urandom_range(0, 1));
      else
        pos = POS_W'($urandom_range(0, SEQ_N - 1));
      sgn = 1'($urandom_range(0, 1));
      send_cmd(op, pos, sgn);
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d writes, %0d recomputes, %0d evaluates and %0d applied flips.",
             sb.cmd_count[CMD_WRITE], sb.cmd_count[CMD_RECOMP],
             sb.cmd_count[CMD_EVAL], sb.cmd_count[CMD_APPLY]);
    $display("Compared %0d results against the predictor, %0d mismatches.",
             sb.checked, sb.fails);
    if (sb.fails == 0 && sb.pending() == 0)
      $display("labs_autocorrelation_flip_engine_tb: PASS");
    else
      $display("labs_autocorrelation_flip_engine_tb: FAIL");
    $finish;
  end

endmodule
